// ===== rtl/efe_pkg.sv =====
// ----------------------------------------------------------------------------
// efe_pkg
// Shared types and constants of the escaped frame encoder: register indexes,
// status codes and the command passed from the front end to the byte engine.
// ----------------------------------------------------------------------------
package efe_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 1;

  // a command holds at most delimiter, two length bytes and a checksum
  localparam int SLOT_COUNT  = 4;
  localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_START_DELIMITER = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_VALUE    = 1'd1;

  localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'h7D;
  localparam logic [BYTE_W-1:0] CHECKSUM_BASE   = 8'hFF;
  localparam logic [BYTE_W-1:0] ESCAPE_FLIP     = 8'h20;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABANDONED = 2'd2;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] start_delimiter;
    logic [BYTE_W-1:0] escape_value;
  } cfg_t;

  typedef struct packed {
    logic                                drop;
    logic [SLOT_COUNT-1:0][BYTE_W-1:0]   slots;
    logic [SLOT_COUNT-1:0]               esc_mask;
    logic [SLOT_IDX_W-1:0]               last_slot;
    logic                                has_eof;
    logic [STATUS_W-1:0]                 status;
  } cmd_t;

endpackage

// ===== rtl/escaped_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_encoder
// Byte-stuffing framer with an 8-bit checksum.
// Input channel (in_valid/in_ready): kind 0 opens a frame of frame_length
// payload bytes, kind 1 delivers one payload byte. Each request yields one or
// more results on the output channel (out_valid/out_ready); last_of_run
// marks the final result of a request and end_of_frame the checksum byte.
// A start request emits delimiter and escaped length bytes (plus checksum for
// a zero-length frame), up to seven results; a data request emits one to four.
// An accepted request is written to the queue, then loaded into the output
// register. The byte engine sends one result per cycle unless the output
// stalls, so sustained rate is set by the output; an escaped payload byte
// yields two results. Requests are taken while the two-entry command queue
// has room, so input and output stall independently.
// Reset clears frame state, queue and output valid; delimiter and escape
// registers return to 0x7E and 0x7D. Config is written via cfg_write.
// When the receiver stalls, the output holds and the queue fills, then
// in_ready drops.
// ----------------------------------------------------------------------------
module escaped_frame_encoder #(
  parameter int QUEUE_DEPTH = efe_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [efe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [efe_pkg::BYTE_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic [efe_pkg::LEN_W-1:0]        frame_length,
  input  logic [efe_pkg::BYTE_W-1:0]       payload_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [efe_pkg::BYTE_W-1:0]       out_byte,
  output logic                             byte_valid,
  output logic                             end_of_frame,
  output logic                             last_of_run,
  output logic [efe_pkg::STATUS_W-1:0]     status
);

  efe_pkg::cfg_t cfg;
  efe_pkg::cmd_t push_cmd;
  efe_pkg::cmd_t head_cmd;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delimiter <= efe_pkg::DELIMITER_RESET;
      cfg.escape_value    <= efe_pkg::ESCAPE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        efe_pkg::REG_START_DELIMITER: cfg.start_delimiter <= cfg_data;
        efe_pkg::REG_ESCAPE_VALUE:    cfg.escape_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  efe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .frame_length (frame_length),
    .payload_byte (payload_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  efe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  efe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_head       (head_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .end_of_frame (end_of_frame),
    .last_of_run  (last_of_run),
    .status       (status)
  );

endmodule

// ===== rtl/efe_front.sv =====
// ----------------------------------------------------------------------------
// efe_front
// Accepts input requests, tracks the open frame (length, running sum) and
// turns each request into one command of raw bytes for the byte engine.
// ----------------------------------------------------------------------------
module efe_front (
  input  logic                        clk,
  input  logic                        rst,
  input  efe_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [efe_pkg::LEN_W-1:0]   frame_length,
  input  logic [efe_pkg::BYTE_W-1:0]  payload_byte,
  input  logic                        q_full,
  output logic                        q_push,
  output efe_pkg::cmd_t               q_cmd
);

  logic                        in_frame;
  logic                        in_frame_next;
  logic [efe_pkg::LEN_W-1:0]   bytes_remaining;
  logic [efe_pkg::LEN_W-1:0]   bytes_remaining_next;
  logic [efe_pkg::BYTE_W-1:0]  running_sum;
  logic [efe_pkg::BYTE_W-1:0]  running_sum_next;
  logic [efe_pkg::BYTE_W-1:0]  sum_plus;
  logic [efe_pkg::LEN_W-1:0]   rem_dec;
  logic                        len_zero;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign sum_plus = running_sum + payload_byte;
  assign rem_dec  = bytes_remaining - efe_pkg::LEN_W'(1);
  assign len_zero = (frame_length == '0);

  always_comb begin
    q_cmd                = '0;
    in_frame_next        = in_frame;
    bytes_remaining_next = bytes_remaining;
    running_sum_next     = running_sum;
    if (kind == efe_pkg::KIND_START) begin
      q_cmd.slots[0]   = cfg.start_delimiter;
      q_cmd.slots[1]   = frame_length[15:8];
      q_cmd.slots[2]   = frame_length[7:0];
      q_cmd.slots[3]   = efe_pkg::CHECKSUM_BASE;
      q_cmd.esc_mask   = 4'b1110;
      q_cmd.last_slot  = len_zero ? efe_pkg::SLOT_IDX_W'(3) : efe_pkg::SLOT_IDX_W'(2);
      q_cmd.has_eof    = len_zero;
      q_cmd.status     = in_frame ? efe_pkg::STATUS_ABANDONED : efe_pkg::STATUS_OK;
      // a zero-length frame closes right away
      in_frame_next        = !len_zero;
      bytes_remaining_next = frame_length;
      running_sum_next     = '0;
    end else if (!in_frame) begin
      q_cmd.drop   = 1'b1;
      q_cmd.status = efe_pkg::STATUS_DROPPED;
    end else begin
      q_cmd.slots[0]  = payload_byte;
      q_cmd.slots[1]  = efe_pkg::CHECKSUM_BASE - sum_plus;
      q_cmd.esc_mask  = 4'b0011;
      q_cmd.last_slot = (rem_dec == '0) ? efe_pkg::SLOT_IDX_W'(1) : efe_pkg::SLOT_IDX_W'(0);
      q_cmd.has_eof   = (rem_dec == '0);
      q_cmd.status    = efe_pkg::STATUS_OK;
      bytes_remaining_next = rem_dec;
      if (rem_dec == '0) begin
        in_frame_next    = 1'b0;
        running_sum_next = '0;
      end else begin
        running_sum_next = sum_plus;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      bytes_remaining <= '0;
      running_sum     <= '0;
    end else if (q_push) begin
      in_frame        <= in_frame_next;
      bytes_remaining <= bytes_remaining_next;
      running_sum     <= running_sum_next;
    end
  end

endmodule

// ===== rtl/efe_queue.sv =====
// ----------------------------------------------------------------------------
// efe_queue
// Small command queue between the front end and the byte engine.
// ----------------------------------------------------------------------------
module efe_queue #(
  parameter int DEPTH = efe_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  efe_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output efe_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  efe_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/efe_back.sv =====
// ----------------------------------------------------------------------------
// efe_back
// Byte engine: walks the slots of the head command, inserts escape bytes and
// drives the registered output channel, one result per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module efe_back (
  input  logic                          clk,
  input  logic                          rst,
  input  efe_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  efe_pkg::cmd_t                 q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [efe_pkg::BYTE_W-1:0]    out_byte,
  output logic                          byte_valid,
  output logic                          end_of_frame,
  output logic                          last_of_run,
  output logic [efe_pkg::STATUS_W-1:0]  status
);

  logic [efe_pkg::SLOT_IDX_W-1:0] idx;
  logic                           half;
  logic [efe_pkg::BYTE_W-1:0]     cur;
  logic                           special;
  logic                           at_last;
  logic                           step_done;
  logic                           run_done;
  logic                           load;
  logic [efe_pkg::BYTE_W-1:0]     nxt_byte;
  logic                           nxt_eof;

  assign cur       = q_head.slots[idx];
  assign special   = q_head.esc_mask[idx] &&
                     (cur == cfg.start_delimiter || cur == cfg.escape_value);
  assign at_last   = (idx == q_head.last_slot);
  assign step_done = !special || half;
  assign run_done  = q_head.drop || (at_last && step_done);
  assign load      = q_valid && (!out_valid || out_ready);
  assign q_pop     = load && run_done;

  always_comb begin
    if (q_head.drop) begin
      nxt_byte = '0;
      nxt_eof  = 1'b0;
    end else if (special && !half) begin
      // first byte of an escaped pair
      nxt_byte = cfg.escape_value;
      nxt_eof  = 1'b0;
    end else begin
      nxt_byte = special ? (cur ^ efe_pkg::ESCAPE_FLIP) : cur;
      nxt_eof  = q_head.has_eof && at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      half      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (run_done) begin
          idx  <= '0;
          half <= 1'b0;
        end else if (step_done) begin
          idx  <= idx + efe_pkg::SLOT_IDX_W'(1);
          half <= 1'b0;
        end else begin
          half <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= nxt_byte;
      byte_valid   <= !q_head.drop;
      end_of_frame <= nxt_eof;
      last_of_run  <= run_done;
      status       <= q_head.status;
    end
  end

  // the checksum byte always closes the run of its request
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_frame) |-> (last_of_run && byte_valid))
    else $error("end_of_frame without last_of_run");

  // mid-pair state only exists while its command is still queued
  a_half_head: assert property (@(posedge clk) disable iff (rst)
    half |-> q_valid)
    else $error("escape pair pending with empty queue");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_head.drop) |-> (idx <= q_head.last_slot))
    else $error("slot index beyond last slot");

  a_pop_resets: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (idx == '0 && !half))
    else $error("slot walker not cleared after command");

endmodule
